// ===== rtl/buzzer_status_pattern_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// buzzer sequencer assertion macros
// clocked assertion helpers used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef BUZZER_STATUS_PATTERN_SEQUENCER_ASSERT_SVH
`define BUZZER_STATUS_PATTERN_SEQUENCER_ASSERT_SVH

// plain implication check, off during reset
`define BSPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs during reset
`define BSPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bsps_pkg.sv =====
// ----------------------------------------------------------------------------
// bsps_pkg
// types, codes and the pattern rom of the buzzer pattern sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsps_pkg;

   localparam int NUM_EVENTS = 22;
   localparam int TBL_STEPS  = 4;

   // commands
   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
   localparam logic [1:0] CMD_EVENT    = 2'd2;

   // register indexes
   localparam logic REG_ENABLE      = 1'b0;
   localparam logic REG_ACTIVE_HIGH = 1'b1;

   // status flag bit positions
   localparam int FLAG_FAULT       = 0;
   localparam int FLAG_LOWBAT      = 1;
   localparam int FLAG_OVERTEMP    = 2;
   localparam int FLAG_OVERCURRENT = 3;
   localparam int FLAG_MAINS       = 4;
   localparam int FLAG_ONBATTERY   = 5;
   localparam int FLAG_CHARGING    = 6;
   localparam int FLAG_BATFULL     = 7;
   localparam int FLAG_RAIL48V     = 8;
   localparam int FLAG_LINKUP      = 9;
   localparam int FLAG_COMMERROR   = 10;

   // event codes
   localparam logic [4:0] EV_STARTUP      = 5'd0;
   localparam logic [4:0] EV_PAIR_REQ     = 5'd1;
   localparam logic [4:0] EV_CFG_PROMPT   = 5'd2;
   localparam logic [4:0] EV_CFG_MODE     = 5'd3;
   localparam logic [4:0] EV_CFG_SAVED    = 5'd4;
   localparam logic [4:0] EV_LINK_FOUND   = 5'd5;
   localparam logic [4:0] EV_LINK_LOST    = 5'd6;
   localparam logic [4:0] EV_MAINS_ON     = 5'd7;
   localparam logic [4:0] EV_MAINS_DROP   = 5'd8;
   localparam logic [4:0] EV_BATTERY_RUN  = 5'd9;
   localparam logic [4:0] EV_CHARGING     = 5'd10;
   localparam logic [4:0] EV_BATTERY_FULL = 5'd11;
   localparam logic [4:0] EV_BATTERY_LOW  = 5'd12;
   localparam logic [4:0] EV_RAIL_ON      = 5'd13;
   localparam logic [4:0] EV_RAIL_OFF     = 5'd14;
   localparam logic [4:0] EV_CURRENT_HIGH = 5'd15;
   localparam logic [4:0] EV_TEMP_HIGH    = 5'd16;
   localparam logic [4:0] EV_COMM_FAIL    = 5'd17;
   localparam logic [4:0] EV_TEST_PASS    = 5'd18;
   localparam logic [4:0] EV_TEST_FAIL    = 5'd19;
   localparam logic [4:0] EV_SHUTDOWN     = 5'd20;
   localparam logic [4:0] EV_SYS_FAULT    = 5'd21;

   typedef struct packed {
      logic [10:0] last_status;
      logic        have_last;
      logic        playing;
      logic [4:0]  active_event;
      logic [1:0]  step_index;
      logic        in_pause;
      logic [7:0]  ms_left;
   } state_type;

   localparam state_type STATE_RESET = '0;

   typedef struct packed {
      logic        tone_on;
      logic [10:0] tone_freq;
      logic        idle_level;
      logic        busy_res;
      logic [4:0]  current_event;
   } result_type;

   typedef struct packed {
      logic [10:0] freq;
      logic [7:0]  dur;
      logic [7:0]  pause;
   } step_type;

   function automatic step_type pat_step(input logic [4:0] ev, input logic [1:0] idx);
      step_type row [TBL_STEPS];
      row = '{default: '0};
      case (ev)
         EV_STARTUP:      row = '{'{11'd700, 8'd60, 8'd40}, '{11'd1200, 8'd60, 8'd40},
                                  '{11'd1700, 8'd80, 8'd0}, '0};
         EV_PAIR_REQ:     row = '{'{11'd900, 8'd60, 8'd60}, '{11'd1200, 8'd60, 8'd60},
                                  '{11'd1500, 8'd120, 8'd200}, '0};
         EV_CFG_PROMPT:   row = '{'{11'd1100, 8'd40, 8'd80}, '{11'd1100, 8'd40, 8'd0}, '0, '0};
         EV_CFG_MODE:     row = '{'{11'd1000, 8'd40, 8'd60}, '{11'd1000, 8'd40, 8'd200},
                                  '{11'd1000, 8'd40, 8'd0}, '0};
         EV_CFG_SAVED:    row = '{'{11'd1400, 8'd60, 8'd40}, '{11'd1800, 8'd80, 8'd0}, '0, '0};
         EV_LINK_FOUND:   row = '{'{11'd1100, 8'd40, 8'd30}, '{11'd1400, 8'd50, 8'd0}, '0, '0};
         EV_LINK_LOST:    row = '{'{11'd1000, 8'd60, 8'd40}, '{11'd800, 8'd60, 8'd0}, '0, '0};
         EV_MAINS_ON:     row = '{'{11'd900, 8'd60, 8'd30}, '{11'd1200, 8'd60, 8'd0}, '0, '0};
         EV_MAINS_DROP:   row = '{'{11'd500, 8'd180, 8'd120}, '{11'd500, 8'd180, 8'd0}, '0, '0};
         EV_BATTERY_RUN:  row = '{'{11'd950, 8'd50, 8'd50}, '{11'd1050, 8'd50, 8'd0}, '0, '0};
         EV_CHARGING:     row = '{'{11'd1200, 8'd30, 8'd40}, '{11'd1200, 8'd30, 8'd0}, '0, '0};
         EV_BATTERY_FULL: row = '{'{11'd1600, 8'd80, 8'd0}, '0, '0, '0};
         EV_BATTERY_LOW:  row = '{'{11'd450, 8'd120, 8'd120}, '{11'd450, 8'd120, 8'd0}, '0, '0};
         EV_RAIL_ON:      row = '{'{11'd1000, 8'd40, 8'd30}, '{11'd1300, 8'd60, 8'd0}, '0, '0};
         EV_RAIL_OFF:     row = '{'{11'd900, 8'd40, 8'd30}, '{11'd700, 8'd60, 8'd0}, '0, '0};
         EV_CURRENT_HIGH: row = '{'{11'd300, 8'd80, 8'd40}, '{11'd300, 8'd80, 8'd40},
                                  '{11'd300, 8'd80, 8'd0}, '0};
         EV_TEMP_HIGH:    row = '{'{11'd2000, 8'd40, 8'd60}, '{11'd2000, 8'd40, 8'd60},
                                  '{11'd2000, 8'd40, 8'd0}, '0};
         EV_COMM_FAIL:    row = '{'{11'd800, 8'd50, 8'd120}, '{11'd800, 8'd50, 8'd0}, '0, '0};
         EV_TEST_PASS:    row = '{'{11'd1200, 8'd50, 8'd30}, '{11'd1500, 8'd50, 8'd30},
                                  '{11'd1800, 8'd60, 8'd0}, '0};
         EV_TEST_FAIL:    row = '{'{11'd500, 8'd80, 8'd60}, '{11'd500, 8'd80, 8'd60},
                                  '{11'd500, 8'd120, 8'd0}, '0};
         EV_SHUTDOWN:     row = '{'{11'd1500, 8'd60, 8'd40}, '{11'd1000, 8'd60, 8'd40},
                                  '{11'd700, 8'd60, 8'd0}, '0};
         EV_SYS_FAULT:    row = '{'{11'd350, 8'd100, 8'd60}, '{11'd350, 8'd100, 8'd60},
                                  '{11'd350, 8'd100, 8'd60}, '{11'd350, 8'd100, 8'd0}};
         default:         row = '{default: '0};
      endcase
      return row[idx];
   endfunction

   function automatic logic [2:0] pat_len(input logic [4:0] ev);
      logic [2:0] n;
      case (ev) inside
         EV_STARTUP, EV_PAIR_REQ, EV_CFG_MODE, EV_CURRENT_HIGH, EV_TEMP_HIGH,
         EV_TEST_PASS, EV_TEST_FAIL, EV_SHUTDOWN: n = 3'd3;
         EV_BATTERY_FULL: n = 3'd1;
         EV_SYS_FAULT:    n = 3'd4;
         default:         n = 3'd2;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/bsps_state_mem.sv =====
// ----------------------------------------------------------------------------
// bsps_state_mem
// single-entry state memory with registered read, write forwarding,
// a valid bit for reset and a pending clear from the enable register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsps_state_mem
   import bsps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  state_type wr_data,
   input  logic      clr_req,
   output state_type rd_state
);

   state_type mem_ff [1];
   state_type rd_data_ff;
   state_type fwd_data_ff;
   logic      fwd_ff;
   logic      valid_ff;
   logic      clr_pend_ff;
   state_type raw;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[0] <= wr_data;
      end
      rd_data_ff  <= mem_ff[0];
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff      <= 1'b0;
         valid_ff    <= 1'b0;
         clr_pend_ff <= 1'b0;
      end else begin
         fwd_ff <= wr_en;
         if (wr_en) begin
            valid_ff <= 1'b1;
         end
         if (clr_req) begin
            clr_pend_ff <= 1'b1;
         end else if (wr_en) begin
            clr_pend_ff <= 1'b0;
         end
      end
   end

   // the read issued with a write sees old data, take the written word instead
   always_comb begin
      if (fwd_ff) begin
         raw = fwd_data_ff;
      end else if (valid_ff) begin
         raw = rd_data_ff;
      end else begin
         raw = STATE_RESET;
      end
      rd_state = raw;
      if (clr_pend_ff) begin
         rd_state.playing    = 1'b0;
         rd_state.in_pause   = 1'b0;
         rd_state.ms_left    = '0;
         rd_state.step_index = '0;
      end
   end

endmodule

// ===== rtl/bsps_update.sv =====
// ----------------------------------------------------------------------------
// bsps_update
// next-state logic for one word: tick, snapshot edge rules, event start,
// plus the result fields seen after the word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsps_update
   import bsps_pkg::*;
#(
   parameter int MAX_STEPS = 4
)
(
   input  state_type   cur,
   input  logic [1:0]  command,
   input  logic [10:0] status_flags,
   input  logic [4:0]  event_code,
   input  logic        enable,
   input  logic        active_high,
   output state_type   nxt,
   output result_type  res
);

   logic [10:0] prev;
   logic [10:0] rise;
   logic [10:0] fall;
   logic        hp;
   logic        snap_fire;
   logic [4:0]  snap_ev;
   logic        start_fire;
   logic [4:0]  start_ev;
   logic        start_ok;
   logic [7:0]  ms_dec;
   logic [2:0]  step_inc;
   step_type    cur_step;
   step_type    inc_step;
   step_type    start_step;
   step_type    out_step;
   logic        on;

   function automatic logic [2:0] steps_of(input logic [4:0] ev);
      logic [2:0] n;
      n = pat_len(ev);
      return (int'(n) < MAX_STEPS) ? n : 3'(MAX_STEPS);
   endfunction

   assign prev = cur.last_status;
   assign hp   = cur.have_last;
   assign rise = status_flags & ~prev;
   assign fall = prev & ~status_flags;

   // later picks override earlier; fault and a mains fall stop the rest
   always_comb begin
      snap_fire = 1'b0;
      snap_ev   = EV_STARTUP;
      if (status_flags[FLAG_FAULT]) begin
         if (!hp || !prev[FLAG_FAULT]) begin
            snap_fire = 1'b1;
            snap_ev   = EV_SYS_FAULT;
         end
      end else begin
         if (status_flags[FLAG_LOWBAT] && (!hp || !prev[FLAG_LOWBAT])) begin
            snap_fire = 1'b1;
            snap_ev   = EV_BATTERY_LOW;
         end
         if (status_flags[FLAG_OVERTEMP] && (!hp || !prev[FLAG_OVERTEMP])) begin
            snap_fire = 1'b1;
            snap_ev   = EV_TEMP_HIGH;
         end
         if (status_flags[FLAG_OVERCURRENT] && (!hp || !prev[FLAG_OVERCURRENT])) begin
            snap_fire = 1'b1;
            snap_ev   = EV_CURRENT_HIGH;
         end
         if (hp) begin
            if (fall[FLAG_MAINS]) begin
               snap_fire = 1'b1;
               snap_ev   = EV_MAINS_DROP;
            end else begin
               if (rise[FLAG_MAINS]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_MAINS_ON;
               end
               if (rise[FLAG_ONBATTERY]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_BATTERY_RUN;
               end
               if (rise[FLAG_CHARGING]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_CHARGING;
               end
               if (rise[FLAG_BATFULL]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_BATTERY_FULL;
               end
               if (rise[FLAG_RAIL48V]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_RAIL_ON;
               end
               if (fall[FLAG_RAIL48V]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_RAIL_OFF;
               end
               if (rise[FLAG_LINKUP]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_LINK_FOUND;
               end
               if (fall[FLAG_LINKUP]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_LINK_LOST;
               end
               if (rise[FLAG_COMMERROR]) begin
                  snap_fire = 1'b1;
                  snap_ev   = EV_COMM_FAIL;
               end
            end
         end else begin
            // first snapshot: levels instead of edges
            if (!status_flags[FLAG_MAINS]) begin
               snap_fire = 1'b1;
               snap_ev   = EV_MAINS_DROP;
            end
            if (status_flags[FLAG_ONBATTERY]) begin
               snap_fire = 1'b1;
               snap_ev   = EV_BATTERY_RUN;
            end
            if (status_flags[FLAG_LOWBAT]) begin
               snap_fire = 1'b1;
               snap_ev   = EV_BATTERY_LOW;
            end
            if (status_flags[FLAG_OVERTEMP]) begin
               snap_fire = 1'b1;
               snap_ev   = EV_TEMP_HIGH;
            end
            if (status_flags[FLAG_OVERCURRENT]) begin
               snap_fire = 1'b1;
               snap_ev   = EV_CURRENT_HIGH;
            end
            if (status_flags[FLAG_RAIL48V]) begin
               snap_fire = 1'b1;
               snap_ev   = EV_RAIL_ON;
            end
         end
      end
   end

   always_comb begin
      start_fire = 1'b0;
      start_ev   = event_code;
      case (command)
         CMD_SNAPSHOT: begin
            start_fire = snap_fire;
            start_ev   = snap_ev;
         end
         CMD_EVENT: begin
            start_fire = 1'b1;
         end
         default: begin
            start_fire = 1'b0;
         end
      endcase
   end

   assign start_ok   = start_fire && enable && (int'(start_ev) < NUM_EVENTS);
   assign ms_dec     = (cur.ms_left != 8'd0) ? (cur.ms_left - 8'd1) : 8'd0;
   assign step_inc   = {1'b0, cur.step_index} + 3'd1;
   assign cur_step   = pat_step(cur.active_event, cur.step_index);
   assign inc_step   = pat_step(cur.active_event, step_inc[1:0]);
   assign start_step = pat_step(start_ev, 2'd0);

   always_comb begin
      nxt = cur;
      if (command == CMD_SNAPSHOT) begin
         nxt.last_status = status_flags;
         nxt.have_last   = 1'b1;
      end
      if (command == CMD_TICK && cur.playing) begin
         nxt.ms_left = ms_dec;
         if (ms_dec == 8'd0) begin
            if (!cur.in_pause && cur_step.pause != 8'd0) begin
               nxt.in_pause = 1'b1;
               nxt.ms_left  = cur_step.pause;
            end else if (step_inc >= steps_of(cur.active_event)
                         || int'(step_inc) >= TBL_STEPS) begin
               nxt.playing    = 1'b0;
               nxt.in_pause   = 1'b0;
               nxt.ms_left    = '0;
               nxt.step_index = '0;
            end else begin
               nxt.step_index = step_inc[1:0];
               nxt.in_pause   = 1'b0;
               nxt.ms_left    = inc_step.dur;
            end
         end
      end
      if (start_ok) begin
         nxt.active_event = start_ev;
         nxt.step_index   = '0;
         nxt.in_pause     = 1'b0;
         if (steps_of(start_ev) == 3'd0) begin
            nxt.playing = 1'b0;
            nxt.ms_left = '0;
         end else begin
            nxt.playing = 1'b1;
            nxt.ms_left = start_step.dur;
         end
      end
   end

   assign out_step          = pat_step(nxt.active_event, nxt.step_index);
   assign on                = nxt.playing && !nxt.in_pause && enable;
   assign res.tone_on       = on;
   assign res.tone_freq     = on ? out_step.freq : 11'd0;
   assign res.idle_level    = ~active_high;
   assign res.busy_res      = nxt.playing;
   assign res.current_event = nxt.active_event;

endmodule

// ===== rtl/buzzer_status_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// buzzer_status_pattern_sequencer
// buzzer annunciator: ticks, status snapshots and event requests in,
// one tone/status word out per input word
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one word per accept (req_valid high, req_stall low):
//   a 1 ms tick, an 11-flag status snapshot or a direct event code.
//   rsp_* returns exactly one word for every request word, in order,
//   giving tone on/frequency, idle pin level, busy and the current event.
//   csr_write/csr_index/csr_wdata set enable (0) and active_high (1);
//   write them only while no word is in flight.
// timing:
//   a word accepted into the update stage is updated there and loaded into
//   the response register once that one is free or being taken; rsp_valid
//   rises with that load. one word is taken every cycle while the response
//   is not stalled. the state record sits in a one-entry memory with a
//   registered read, and the word written back is forwarded to the next word.
// reset and stall:
//   reset empties the pipeline, sets both registers to 1 and makes the
//   state read as all zero until it is first written. a stalled response
//   holds; the word behind it waits in the update stage and req_stall rises
//   only when that stage is also full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buzzer_status_pattern_sequencer
   import bsps_pkg::*;
#(
   parameter int MAX_STEPS = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [10:0] req_status_flags,
   input  logic [4:0]  req_event_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tone_on,
   output logic [10:0] rsp_tone_freq,
   output logic        rsp_idle_level,
   output logic        rsp_busy_res,
   output logic [4:0]  rsp_current_event,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   `include "buzzer_status_pattern_sequencer_assert.svh"

   logic        enable_ff;
   logic        active_high_ff;
   logic        s1_valid_ff;
   logic [1:0]  s1_command_ff;
   logic [10:0] s1_flags_ff;
   logic [4:0]  s1_code_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        req_take;
   logic        s1_go;
   logic        clr_req;
   state_type   cur_state;
   state_type   nxt_state;
   result_type  res;

   assign s1_go     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign clr_req   = csr_write && csr_index == REG_ENABLE && !csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b1;
         active_high_ff <= 1'b1;
      end else if (csr_write) begin
         if (csr_index == REG_ENABLE) begin
            enable_ff <= csr_wdata;
         end
         if (csr_index == REG_ACTIVE_HIGH) begin
            active_high_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_command;
         s1_flags_ff   <= req_status_flags;
         s1_code_ff    <= req_event_code;
      end
      if (s1_go) begin
         out_ff <= res;
      end
   end

   bsps_state_mem u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (s1_go),
      .wr_data  (nxt_state),
      .clr_req  (clr_req),
      .rd_state (cur_state)
   );

   bsps_update #(
      .MAX_STEPS (MAX_STEPS)
   ) u_update (
      .cur          (cur_state),
      .command      (s1_command_ff),
      .status_flags (s1_flags_ff),
      .event_code   (s1_code_ff),
      .enable       (enable_ff),
      .active_high  (active_high_ff),
      .nxt          (nxt_state),
      .res          (res)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_tone_on       = out_ff.tone_on;
   assign rsp_tone_freq     = out_ff.tone_freq;
   assign rsp_idle_level    = out_ff.idle_level;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_current_event = out_ff.current_event;

   `BSPS_ASSERT(a_tone_needs_busy, clock, reset,
      rsp_valid && rsp_tone_on |-> rsp_busy_res, "tone sounding with no pattern")
   `BSPS_ASSERT(a_silent_zero_freq, clock, reset,
      rsp_valid && !rsp_tone_on |-> rsp_tone_freq == 11'd0, "frequency while silent")
   `BSPS_ASSERT(a_stalled_word_kept, clock, reset,
      s1_valid_ff && !s1_go |=> s1_valid_ff, "update stage dropped a word")
   `BSPS_ASSERT_ALWAYS(a_take_fills_stage, clock,
      !reset && req_take |=> s1_valid_ff || reset, "accepted word not in update stage")

endmodule
